>>> design/sts_pkg.sv
// shared constants, token kind codes, keyword table and transfer control struct
// for the script token scanner; no dependencies
package sts_pkg;

	localparam int LINE_BITS_DEF   = 24;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 24;
	localparam int QUEUE_DEPTH     = 4;

	localparam int KIND_BITS  = 6;
	localparam int GLYPH_BITS = 8;

	typedef logic [KIND_BITS-1:0] kind_t;

	// token kinds
	localparam kind_t KIND_IDENT     = 6'd14;
	localparam kind_t KIND_INT       = 6'd15;
	localparam kind_t KIND_DOUBLE    = 6'd16;
	localparam kind_t KIND_STRING    = 6'd17;
	localparam kind_t KIND_BANG      = 6'd18;
	localparam kind_t KIND_COMMA     = 6'd20;
	localparam kind_t KIND_EQUAL     = 6'd21;
	localparam kind_t KIND_GREATER   = 6'd23;
	localparam kind_t KIND_LESS      = 6'd25;
	localparam kind_t KIND_MINUS     = 6'd27;
	localparam kind_t KIND_LPAREN    = 6'd28;
	localparam kind_t KIND_RPAREN    = 6'd29;
	localparam kind_t KIND_PERCENT   = 6'd30;
	localparam kind_t KIND_PLUS      = 6'd31;
	localparam kind_t KIND_SEMICOLON = 6'd33;
	localparam kind_t KIND_SLASH     = 6'd34;
	localparam kind_t KIND_STAR      = 6'd36;
	localparam kind_t KIND_EOF       = 6'd37;
	localparam kind_t KIND_BAD_GLYPH = 6'd38;
	localparam kind_t KIND_UNTERM    = 6'd39;

	// keywords, first character in the low byte, zero padded; index is the kind
	localparam int NUM_KEYWORDS = 14;
	localparam logic [39:0] KEYWORDS [NUM_KEYWORDS] = '{
		40'h0000646e61, // and
		40'h6b61657262, // break
		40'h0000006f64, // do
		40'h0065736c65, // else
		40'h0000646e65, // end
		40'h65736c6166, // false
		40'h0000726f66, // for
		40'h00006e7566, // fun
		40'h0000006669, // if
		40'h000000726f, // or
		40'h746e697270, // print
		40'h0065757274, // true
		40'h0000726176, // var
		40'h656c696877  // while
	};

	// which tokens an accepted byte pushes into the result queue
	typedef struct packed {
		logic push0;
		logic push1;
	} emit_t;

	function automatic kind_t word_kind(input logic [39:0] window, input logic fits);
		kind_t kind;
		kind = KIND_IDENT;
		if (fits) begin
			for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
				if (window == KEYWORDS[k]) begin
					kind = KIND_BITS'(k);
				end
			end
		end
		return kind;
	endfunction

	function automatic logic is_name_start(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

>>> design/sts_lexer.sv
// scan state registers and the per-byte scanning logic of the token scanner
// depends on sts_pkg
module sts_lexer #(
	parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sts_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = sts_pkg::LENGTH_BITS_DEF,
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF,
	parameter int TOK_W       = sts_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS
		+ LENGTH_BITS + OFFSET_BITS + sts_pkg::GLYPH_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         text_byte,
	output sts_pkg::emit_t     emit,
	output logic [TOK_W-1:0]   tok0_data,
	output logic [TOK_W-1:0]   tok1_data
);
	import sts_pkg::*;

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_IDENT   = 4'd1;
	localparam logic [3:0] M_INT     = 4'd2;
	localparam logic [3:0] M_DOUBLE  = 4'd3;
	localparam logic [3:0] M_STRING  = 4'd4;
	localparam logic [3:0] M_COMMENT = 4'd5;
	localparam logic [3:0] M_BANG    = 4'd6;
	localparam logic [3:0] M_EQUAL   = 4'd7;
	localparam logic [3:0] M_GREAT   = 4'd8;
	localparam logic [3:0] M_LESS    = 4'd9;
	localparam logic [3:0] M_PLUS    = 4'd10;
	localparam logic [3:0] M_SLASH   = 4'd11;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2a;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_LESS    = 8'h3c;
	localparam logic [7:0] CH_EQUAL   = 8'h3d;
	localparam logic [7:0] CH_GREAT   = 8'h3e;

	logic [3:0]             mode_q, mode_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] col_q, col_d, tcol_q, tcol_d;
	logic [OFFSET_BITS-1:0] off_q, off_d, toff_q, toff_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [39:0]            win_q, win_d;

	logic [COLUMN_BITS-1:0] col_adv;
	logic [OFFSET_BITS-1:0] off_adv;
	logic [LINE_BITS-1:0]   line_adv;
	logic [LENGTH_BITS-1:0] len_ext;
	logic [39:0]            win_ext;
	logic [7:0]             op_second;
	kind_t                  op_single;

	logic                   a_vld, b_vld, rescan;
	kind_t                  a_kind, b_kind;
	logic [LENGTH_BITS-1:0] a_len, b_len;
	logic [7:0]             b_glyph;

	assign col_adv  = (col_q == '1) ? col_q : col_q + 1'b1;
	assign off_adv  = (off_q == '1) ? off_q : off_q + 1'b1;
	assign line_adv = (line_q == '1) ? line_q : line_q + 1'b1;
	assign len_ext  = (len_q == '1) ? len_q : len_q + 1'b1;

	// first five characters of the pending token
	always_comb begin
		win_ext = win_q;
		for (int k = 0; k < 5; k++) begin
			if (len_q == LENGTH_BITS'(k)) begin
				win_ext[8*k +: 8] = win_q[8*k +: 8] | text_byte;
			end
		end
	end

	// paired operators: the byte that completes the pair and the lone kind
	always_comb begin
		unique case (mode_q)
			M_BANG:  begin op_second = CH_EQUAL; op_single = KIND_BANG;    end
			M_EQUAL: begin op_second = CH_EQUAL; op_single = KIND_EQUAL;   end
			M_GREAT: begin op_second = CH_EQUAL; op_single = KIND_GREATER; end
			M_LESS:  begin op_second = CH_EQUAL; op_single = KIND_LESS;    end
			M_PLUS:  begin op_second = CH_PLUS;  op_single = KIND_PLUS;    end
			M_SLASH: begin op_second = CH_SLASH; op_single = KIND_SLASH;   end
			default: begin op_second = CH_SLASH; op_single = KIND_SLASH;   end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		line_d = line_q;
		col_d  = col_q;
		off_d  = off_q;
		tcol_d = tcol_q;
		toff_d = toff_q;
		len_d  = len_q;
		win_d  = win_q;
		a_vld  = 1'b0;
		a_kind = KIND_IDENT;
		a_len  = len_q;
		b_vld  = 1'b0;
		b_kind = KIND_EOF;
		b_len  = LENGTH_BITS'(1);
		b_glyph = '0;
		rescan = 1'b1;

		// close or grow the pending token
		unique case (mode_q)
			M_IDENT: begin
				if (is_name_start(text_byte) || is_digit(text_byte)) begin
					win_d = win_ext; len_d = len_ext;
					col_d = col_adv; off_d = off_adv;
					rescan = 1'b0;
				end else begin
					a_vld  = 1'b1;
					a_kind = word_kind(win_q, len_q <= LENGTH_BITS'(5));
				end
			end
			M_INT, M_DOUBLE: begin
				if (is_digit(text_byte) || (mode_q == M_INT && text_byte == CH_DOT)) begin
					win_d = win_ext; len_d = len_ext;
					col_d = col_adv; off_d = off_adv;
					if (text_byte == CH_DOT) begin
						mode_d = M_DOUBLE;
					end
					rescan = 1'b0;
				end else begin
					a_vld  = 1'b1;
					a_kind = (mode_q == M_INT) ? KIND_INT : KIND_DOUBLE;
				end
			end
			M_STRING: begin
				if (text_byte == CH_QUOTE) begin
					a_vld  = 1'b1;
					a_kind = KIND_STRING;
					col_d  = col_adv; off_d = off_adv;
					mode_d = M_IDLE;
					rescan = 1'b0;
				end else if (text_byte != CH_NUL) begin
					win_d = win_ext; len_d = len_ext;
					col_d = col_adv; off_d = off_adv;
					rescan = 1'b0;
				end else begin
					a_vld  = 1'b1;
					a_kind = KIND_UNTERM;
				end
			end
			M_COMMENT: begin
				if (text_byte == CH_LF) begin
					line_d = line_adv; col_d = '0; off_d = off_adv;
					mode_d = M_IDLE;
					rescan = 1'b0;
				end else if (text_byte != CH_NUL) begin
					col_d = col_adv; off_d = off_adv;
					rescan = 1'b0;
				end
			end
			M_BANG, M_EQUAL, M_GREAT, M_LESS, M_PLUS, M_SLASH: begin
				a_vld = 1'b1;
				if (text_byte == op_second) begin
					a_kind = op_single + 1'b1;
					a_len  = LENGTH_BITS'(2);
					col_d  = col_adv; off_d = off_adv;
					mode_d = M_IDLE;
					rescan = 1'b0;
				end else begin
					a_kind = op_single;
					a_len  = LENGTH_BITS'(1);
				end
			end
			default: begin
				rescan = 1'b1;
			end
		endcase

		// scan the byte afresh from idle
		if (rescan) begin
			mode_d = M_IDLE;
			case (text_byte) inside
				CH_SPACE, CH_CR, CH_TAB: begin
					col_d = col_adv; off_d = off_adv;
				end
				CH_LF: begin
					line_d = line_adv; col_d = '0; off_d = off_adv;
				end
				CH_NUL: begin
					b_vld = 1'b1; b_kind = KIND_EOF; b_len = '0;
					off_d = '0;
				end
				CH_QUOTE: begin
					col_d = col_adv; off_d = off_adv;
					tcol_d = col_adv; toff_d = off_adv;
					len_d = '0; win_d = '0;
					mode_d = M_STRING;
				end
				CH_HASH: begin
					col_d = col_adv; off_d = off_adv;
					mode_d = M_COMMENT;
				end
				CH_BANG, CH_EQUAL, CH_GREAT, CH_LESS, CH_PLUS, CH_SLASH: begin
					tcol_d = col_q; toff_d = off_q;
					len_d = LENGTH_BITS'(1); win_d = {32'd0, text_byte};
					col_d = col_adv; off_d = off_adv;
					case (text_byte)
						CH_BANG:  mode_d = M_BANG;
						CH_EQUAL: mode_d = M_EQUAL;
						CH_GREAT: mode_d = M_GREAT;
						CH_LESS:  mode_d = M_LESS;
						CH_PLUS:  mode_d = M_PLUS;
						default:  mode_d = M_SLASH;
					endcase
				end
				CH_COMMA, CH_MINUS, CH_LPAREN, CH_RPAREN, CH_PERCENT, CH_SEMI, CH_STAR: begin
					b_vld = 1'b1;
					col_d = col_adv; off_d = off_adv;
					case (text_byte)
						CH_COMMA:   b_kind = KIND_COMMA;
						CH_MINUS:   b_kind = KIND_MINUS;
						CH_LPAREN:  b_kind = KIND_LPAREN;
						CH_RPAREN:  b_kind = KIND_RPAREN;
						CH_PERCENT: b_kind = KIND_PERCENT;
						CH_SEMI:    b_kind = KIND_SEMICOLON;
						default:    b_kind = KIND_STAR;
					endcase
				end
				default: begin
					col_d = col_adv; off_d = off_adv;
					if (is_name_start(text_byte) || is_digit(text_byte)) begin
						tcol_d = col_q; toff_d = off_q;
						len_d = LENGTH_BITS'(1); win_d = {32'd0, text_byte};
						mode_d = is_name_start(text_byte) ? M_IDENT : M_INT;
					end else begin
						b_vld = 1'b1; b_kind = KIND_BAD_GLYPH; b_glyph = text_byte;
					end
				end
			endcase
		end
	end

	// tokens packed with the closed token first
	always_comb begin
		if (a_vld) begin
			tok0_data = {a_kind, line_q, tcol_q, a_len, toff_q, 8'd0, !b_vld};
		end else begin
			tok0_data = {b_kind, line_q, col_q, b_len, off_q, b_glyph, 1'b1};
		end
		tok1_data = {b_kind, line_q, col_q, b_len, off_q, b_glyph, 1'b1};
		emit.push0 = take && (a_vld || b_vld);
		emit.push1 = take && a_vld && b_vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= '0;
			off_q  <= '0;
			tcol_q <= '0;
			toff_q <= '0;
			len_q  <= '0;
			win_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			line_q <= line_d;
			col_q  <= col_d;
			off_q  <= off_d;
			tcol_q <= tcol_d;
			toff_q <= toff_d;
			len_q  <= len_d;
			win_q  <= win_d;
		end
	end

endmodule

>>> design/sts_queue.sv
// small result queue that takes up to two entries per cycle and gives one
// per cycle unless rd_stall is high; depends on sts_pkg
module sts_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sts_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sts_pkg::emit_t   emit,
	input  logic [WIDTH-1:0] wdata0,
	input  logic [WIDTH-1:0] wdata1,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_stall,
	output logic [WIDTH-1:0] rdata
);
	import sts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_next, wr_next2, rd_next;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign wr_next  = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign wr_next2 = (wr_next == LAST) ? '0 : wr_next + 1'b1;
	assign rd_next  = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	assign rd_valid = count_q != '0;
	assign rdata    = slot_q[rd_ptr_q];
	assign pop      = rd_valid && !rd_stall;
	// set when there is no room for two more entries
	assign full     = count_q > CNT_W'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (emit.push0) begin
			slot_q[wr_ptr_q] <= wdata0;
		end
		if (emit.push1) begin
			slot_q[wr_next] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (emit.push1) begin
				wr_ptr_q <= wr_next2;
			end else if (emit.push0) begin
				wr_ptr_q <= wr_next;
			end
			if (pop) begin
				rd_ptr_q <= rd_next;
			end
			count_q <= count_q + CNT_W'(emit.push0) + CNT_W'(emit.push1) - CNT_W'(pop);
		end
	end

endmodule

>>> design/script_token_scanner.sv
// Script token scanner: takes one source byte per transfer and returns tokens
// (keywords, identifiers, integers, doubles, strings, operators, end of text
// and error kinds), each with line, start column, length and start offset.
// A byte is taken every cycle as long as the result queue has room for two
// tokens; all scanning for a byte is done in the cycle it is taken, and the
// tokens it closes are written into the queue at that edge. A byte closes at
// most two tokens; the queue drains one per transfer, so bytes that close two
// tokens fill it and make src_stall rise once the queue holds QUEUE_DEPTH-1
// tokens. Line, column, offset and length counters saturate.
// Depends on sts_pkg, sts_lexer and sts_queue.
module script_token_scanner #(
	parameter int LINE_BITS   = sts_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = sts_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = sts_pkg::LENGTH_BITS_DEF,
	parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// source byte channel
	input  logic                   src_valid,
	output logic                   src_stall,
	input  logic [7:0]             text_byte,
	// token channel
	output logic                   tok_valid,
	input  logic                   tok_stall,
	output logic [5:0]             token_kind,
	output logic [LINE_BITS-1:0]   line_number,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [LENGTH_BITS-1:0] lexeme_length,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [7:0]             bad_glyph,
	output logic                   last_of_run
);
	import sts_pkg::*;

	localparam int TOK_W = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS
		+ OFFSET_BITS + GLYPH_BITS + 1;

	logic             take;
	emit_t            emit;
	logic [TOK_W-1:0] tok0_data, tok1_data, head_data;
	logic             queue_full;

	// a byte transfer happens whenever the source is valid and the queue can absorb two tokens
	assign src_stall = queue_full;
	assign take      = src_valid && !src_stall;

	// scan state and per-byte token logic
	sts_lexer #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.LENGTH_BITS (LENGTH_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.TOK_W       (TOK_W)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text_byte),
		.emit      (emit),
		.tok0_data (tok0_data),
		.tok1_data (tok1_data)
	);

	// result queue parts the scanner from the token consumer
	sts_queue #(
		.WIDTH (TOK_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.emit     (emit),
		.wdata0   (tok0_data),
		.wdata1   (tok1_data),
		.full     (queue_full),
		.rd_valid (tok_valid),
		.rd_stall (tok_stall),
		.rdata    (head_data)
	);

	// token fields, kind in the top bits down to the last-of-run flag
	assign {token_kind, line_number, start_column, lexeme_length,
		start_offset, bad_glyph, last_of_run} = head_data;

`ifndef SYNTHESIS
	// a waiting token only leaves through a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tok_valid) |-> $past(tok_valid && !tok_stall))
		else $error("token dropped without a transfer");

	// end of text always yields a token
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && text_byte == 8'h00) |=> tok_valid)
		else $error("end of text produced no token");

	// an empty queue never holds off the source
	assert property (@(posedge clk) disable iff (!arst_n)
		!tok_valid |-> !src_stall)
		else $error("source stalled with an empty queue");

	// only the unknown-glyph kind carries a glyph
	assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && bad_glyph != 8'h00) |-> token_kind == KIND_BAD_GLYPH)
		else $error("glyph on a token that is not an unknown glyph");
`endif

endmodule
